>>> hw/rtl/assert_macros.svh
// Assertion macros used by the thermostat RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of i_clk, muted while i_rst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never be true on a clock edge.
`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_CLK(lbl, !(cond), msg)

`endif

>>> hw/rtl/adt_pkg.sv
// Package: field widths, register codes and scaling constants of the thermostat.
`timescale 1ns / 1ps

package adt_pkg;

    // Item field widths
    localparam int ADC_W  = 10;
    localparam int TEMP_W = 8;
    localparam int DB_W   = 8;

    // Stream data widths, padded to whole bytes
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_HEATING_ENABLED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND        = 1'd1;

    localparam logic [DB_W-1:0] DEADBAND_RST = 8'd5;

    // Degrees = floor(adc * 489 / 1000), done as adc * 489 * ceil(2^29 / 1000) >> 29
    localparam int                  SCALE_MUL_W = 28;
    localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = 28'd262529919;
    localparam int                  SCALE_SHIFT = 29;
    localparam int                  SCALE_PROD_W = ADC_W + SCALE_MUL_W;
    localparam int                  SCALE_Q_W = 9;
    localparam logic [TEMP_W-1:0]   TEMP_MAX = 8'd255;

endpackage

>>> hw/rtl/averaged_deadband_thermostat.sv
// Top level: moving-average thermostat with dead band, heater/cooler drives and LED.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel  | dir | handshake                          | payload
// s_axis   | in  | i_s_axis_tvalid / o_s_axis_tready  | i_s_axis_tdata: adc_sample, setpoint
// m_axis   | out | o_m_axis_tvalid / i_m_axis_tready  | o_m_axis_tdata: mean_deg, drives, LED
// cfg      | in  | i_cfg_valid / o_cfg_ready          | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while m_axis is ready; each result is registered through
// stage 1 (ring RAM read), stage 2 (sum update, write-back), output (average, drives).
// The ring lives in a RAM with a registered read; consecutive items touch different entries.
// Reset (synchronous, active low) clears the per-entry valid bits at once, so the ring
// reads as zeros immediately; no clearing pass is needed and the config port never stalls.
// Backpressure on m_axis stalls the stages in turn; two items can still enter behind a
// waiting result.

module averaged_deadband_thermostat
    import adt_pkg::*;
#(
    parameter int WINDOW      = 10,
    parameter int BLINK_TICKS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [9:0] adc_sample, [17:10] setpoint, [23:18] zero
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,

    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [7:0] mean_deg, [8] heat_cmd, [9] cool_cmd, [10] led_on, [15:11] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int AW        = $clog2(WINDOW);
    localparam int SUM_W     = TEMP_W + AW;
    localparam int AVG_SHIFT = SUM_W + AW;
    localparam int AVG_MUL_W = SUM_W + 1;
    localparam int AVG_PROD_W = SUM_W + AVG_MUL_W;
    localparam longint unsigned AVG_MUL_L =
        ((64'd1 << AVG_SHIFT) + WINDOW - 1) / WINDOW;
    localparam logic [AVG_MUL_W-1:0] AVG_MUL = AVG_MUL_W'(AVG_MUL_L);
    localparam int BLINK_W   = $clog2(BLINK_TICKS + 1);

    // Configuration registers
    logic            r_en;
    logic [DB_W-1:0] r_db;

    // Ring pointer (accept side), running sum and valid bits
    logic [AW-1:0]    r_wpos;
    logic [SUM_W-1:0] r_sum;
    logic [WINDOW-1:0] r_ring_vld;

    // Stage 1: item with RAM read in flight
    logic              r_s1_v;
    logic              r_s1_en;
    logic [TEMP_W-1:0] r_s1_temp;
    logic [TEMP_W-1:0] r_s1_set;
    logic [AW-1:0]     r_s1_addr;

    // Stage 2: updated sum
    logic              r_s2_v;
    logic              r_s2_en;
    logic [SUM_W-1:0]  r_s2_sum;
    logic [TEMP_W-1:0] r_s2_set;

    // Output stage: thermostat state doubles as the result register
    logic               r_o_v;
    logic [TEMP_W-1:0]  r_last_avg;
    logic               r_heat;
    logic               r_cool;
    logic               r_led;
    logic [BLINK_W-1:0] r_blink;

    logic [TEMP_W-1:0]  n_last_avg;
    logic               n_heat;
    logic               n_cool;
    logic               n_led;
    logic [BLINK_W-1:0] n_blink;

    // Stage handshakes
    logic ld_out, ld_s2, ld_s1, s1_ready;

    assign ld_out   = r_s2_v && (!r_o_v || i_m_axis_tready);
    assign ld_s2    = r_s1_v && (!r_s2_v || ld_out);
    assign s1_ready = !r_s1_v || ld_s2;
    assign ld_s1    = i_s_axis_tvalid && s1_ready;

    assign o_s_axis_tready = s1_ready;
    assign o_cfg_ready     = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0;
            r_db <= DEADBAND_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HEATING_ENABLED: r_en <= i_cfg_data[0];
                CFG_DEADBAND:        r_db <= i_cfg_data[DB_W-1:0];
                default: ;
            endcase
        end
    end

    // Input fields and sample scaling: one constant multiply, then saturate
    logic [ADC_W-1:0]        in_adc;
    logic [TEMP_W-1:0]       in_set;
    logic [SCALE_PROD_W-1:0] scale_prod;
    logic [SCALE_Q_W-1:0]    scale_q;
    logic [TEMP_W-1:0]       scale_temp;

    assign in_adc     = i_s_axis_tdata[ADC_W-1:0];
    assign in_set     = i_s_axis_tdata[ADC_W +: TEMP_W];
    assign scale_prod = SCALE_PROD_W'(in_adc) * SCALE_PROD_W'(SCALE_MUL);
    assign scale_q    = scale_prod[SCALE_SHIFT +: SCALE_Q_W];
    assign scale_temp = (scale_q > SCALE_Q_W'(TEMP_MAX)) ? TEMP_MAX : scale_q[TEMP_W-1:0];

    // Ring RAM: read the entry about to be replaced at accept, write it back in stage 1
    logic              ram_re;
    logic              ram_we;
    logic [TEMP_W-1:0] ram_rdata;
    logic [TEMP_W-1:0] old_temp;
    logic [SUM_W-1:0]  new_sum;

    assign ram_re = ld_s1 && r_en;
    assign ram_we = ld_s2 && r_s1_en;

    adt_ram #(
        .WIDTH (TEMP_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_addr),
        .i_wdata (r_s1_temp),
        .i_re    (ram_re),
        .i_raddr (r_wpos),
        .o_rdata (ram_rdata)
    );

    // Entries not yet written since reset read as zero
    assign old_temp = r_ring_vld[r_s1_addr] ? ram_rdata : '0;
    assign new_sum  = r_sum - SUM_W'(old_temp) + SUM_W'(r_s1_temp);

    // Accept stage and ring pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_wpos <= '0;
        end else begin
            if (ld_s1) begin
                r_s1_v <= 1'b1;
            end else if (ld_s2) begin
                r_s1_v <= 1'b0;
            end
            if (ram_re) begin
                r_wpos <= (r_wpos == AW'(WINDOW - 1)) ? '0 : r_wpos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_s1) begin
            r_s1_en   <= r_en;
            r_s1_temp <= scale_temp;
            r_s1_set  <= in_set;
            r_s1_addr <= r_wpos;
        end
    end

    // Stage 1 to 2: running sum and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v     <= 1'b0;
            r_sum      <= '0;
            r_ring_vld <= '0;
        end else begin
            if (ld_s2) begin
                r_s2_v <= 1'b1;
            end else if (ld_out) begin
                r_s2_v <= 1'b0;
            end
            if (ram_we) begin
                r_sum                 <= new_sum;
                r_ring_vld[r_s1_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_s2) begin
            r_s2_en  <= r_s1_en;
            r_s2_sum <= new_sum;
            r_s2_set <= r_s1_set;
        end
    end

    // Average by reciprocal multiply, then dead-band decision
    logic [AVG_PROD_W-1:0] avg_prod;
    logic [TEMP_W-1:0]     avg;
    logic                  too_hot;
    logic                  too_cold;
    logic [BLINK_W-1:0]    blink_inc;

    assign avg_prod = AVG_PROD_W'(r_s2_sum) * AVG_PROD_W'(AVG_MUL);
    assign avg      = avg_prod[AVG_SHIFT +: TEMP_W];
    assign too_hot  = (avg > r_s2_set) && ((avg - r_s2_set) > r_db);
    assign too_cold = (r_s2_set > avg) && ((r_s2_set - avg) > r_db);

    always_comb begin
        n_last_avg = r_last_avg;
        n_heat     = r_heat;
        n_cool     = r_cool;
        n_led      = r_led;
        n_blink    = r_blink;
        blink_inc  = '0;
        if (r_s2_en) begin
            n_last_avg = avg;
            if (too_hot) begin
                n_cool  = 1'b1;
                n_heat  = 1'b0;
                n_blink = '0;
            end else if (too_cold) begin
                n_heat = 1'b1;
                n_cool = 1'b0;
            end
            // LED: steady when cooling, blinking when heating
            if (n_cool) begin
                n_led = 1'b1;
            end else if (n_heat) begin
                blink_inc = n_blink + 1'b1;
                if (blink_inc >= BLINK_W'(BLINK_TICKS)) begin
                    n_led   = ~r_led;
                    n_blink = '0;
                end else begin
                    n_blink = blink_inc;
                end
            end else begin
                n_led = 1'b0;
            end
        end else begin
            n_heat = 1'b0;
            n_cool = 1'b0;
            n_led  = 1'b0;
        end
    end

    // Output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v      <= 1'b0;
            r_last_avg <= '0;
            r_heat     <= 1'b0;
            r_cool     <= 1'b0;
            r_led      <= 1'b0;
            r_blink    <= '0;
        end else begin
            if (ld_out) begin
                r_o_v      <= 1'b1;
                r_last_avg <= n_last_avg;
                r_heat     <= n_heat;
                r_cool     <= n_cool;
                r_led      <= n_led;
                r_blink    <= n_blink;
            end else if (i_m_axis_tready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_o_v;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - TEMP_W - 3)'(0), r_led, r_cool, r_heat, r_last_avg};

    // Checks
    `ASSERT_NEVER(a_drive_excl, r_heat && r_cool, "heater and cooler both driven")
    `ASSERT_CLK(a_led_idle, (!r_heat && !r_cool) |-> !r_led, "LED lit with no drive active")
    `ASSERT_CLK(a_ram_conflict, (ram_we && ram_re) |-> (r_s1_addr != r_wpos), "ring collision")
    `ASSERT_CLK(a_blink_range, r_blink < BLINK_W'(BLINK_TICKS), "blink count out of range")

endmodule

>>> hw/rtl/adt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module adt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> tb/sv/averaged_deadband_thermostat_tb.sv
// Testbench for the averaged dead-band thermostat: predictor, stimulus and result checks.
`timescale 1ns / 1ps

module averaged_deadband_thermostat_tb
    import adt_pkg::*;
();

    localparam int WINDOW      = 10;
    localparam int BLINK_TICKS = 10;

    typedef struct packed {
        logic [TEMP_W-1:0] mean_deg;
        logic              heat_cmd;
        logic              cool_cmd;
        logic              led_on;
    } t_thermo_result;

    typedef enum {
        STALL_NONE,
        STALL_RANDOM,
        STALL_BURSTY
    } t_stall_mode;

    // DUT ports, inputs driven to known values from time zero
    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b1;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   i_cfg_valid     = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data      = '0;

    // Predicted thermostat state, at its reset values
    int                 ring_deg [WINDOW];
    int                 ring_wr     = 0;
    int                 ring_total  = 0;
    logic [TEMP_W-1:0]  held_avg    = '0;
    logic               heat_q      = 1'b0;
    logic               cool_q      = 1'b0;
    logic               led_q       = 1'b0;
    int                 blink_ticks = 0;
    logic               regulate_en = 1'b0;
    int                 band_deg    = int'(DEADBAND_RST);

    t_thermo_result     expected_q [$];
    int                 errors      = 0;

    // Traffic shaping
    bit                 sender_gaps = 1'b0;
    int                 burst_left  = 0;
    t_stall_mode        stall_mode  = STALL_NONE;
    int                 ready_left  = 0;

    averaged_deadband_thermostat #(
        .WINDOW      (WINDOW),
        .BLINK_TICKS (BLINK_TICKS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        for (int k = 0; k < WINDOW; k++) ring_deg[k] = 0;
    end

    // One tick of the thermostat: advance the predicted state, return the result
    function automatic t_thermo_result predict_tick(input logic [ADC_W-1:0] adc,
                                                    input logic [TEMP_W-1:0] setpoint);
        int             deg;
        int             avg;
        int             sp;
        t_thermo_result res;
        sp = int'(setpoint);
        if (regulate_en) begin
            deg = (int'(adc) * 489) / 1000;
            if (deg > 255) deg = 255;
            ring_total = ring_total - ring_deg[ring_wr] + deg;
            ring_deg[ring_wr] = deg;
            ring_wr = (ring_wr + 1) % WINDOW;
            avg = ring_total / WINDOW;
            if (avg > 255) avg = 255;
            held_avg = avg[TEMP_W-1:0];

            // cooler test wins; both drives hold inside the band
            if (avg > sp && avg - sp > band_deg) begin
                cool_q      = 1'b1;
                heat_q      = 1'b0;
                blink_ticks = 0;
            end else if (sp > avg && sp - avg > band_deg) begin
                heat_q = 1'b1;
                cool_q = 1'b0;
            end

            if (cool_q) begin
                led_q = 1'b1;
            end else if (heat_q) begin
                blink_ticks++;
                if (blink_ticks >= BLINK_TICKS) begin
                    led_q       = ~led_q;
                    blink_ticks = 0;
                end
            end else begin
                led_q = 1'b0;
            end
        end else begin
            heat_q = 1'b0;
            cool_q = 1'b0;
            led_q  = 1'b0;
        end
        res.mean_deg = held_avg;
        res.heat_cmd = heat_q;
        res.cool_cmd = cool_q;
        res.led_on   = led_q;
        return res;
    endfunction

    function automatic int clamp_deg(input int v);
        if (v < 0) return 0;
        if (v > 255) return 255;
        return v;
    endfunction

    // Raw conversion that lands on roughly the given temperature
    function automatic logic [ADC_W-1:0] adc_for_degrees(input int deg);
        int a;
        a = (deg * 1000 + 488) / 489 + int'($urandom_range(0, 1));
        if (deg >= 250 && $urandom_range(0, 1) == 1) a = int'($urandom_range(511, 1023));
        if (a > 1023) a = 1023;
        return a[ADC_W-1:0];
    endfunction

    // Send one item; called and returning at a falling edge
    task automatic send_reading(input logic [ADC_W-1:0] adc, input logic [TEMP_W-1:0] sp);
        i_s_axis_tdata  = {{(IN_TDATA_W - ADC_W - TEMP_W){1'b0}}, sp, adc};
        i_s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        expected_q.push_back(predict_tick(adc, sp));
        @(negedge i_clk);
        if (sender_gaps) begin
            if (burst_left == 0) begin
                i_s_axis_tvalid = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
                burst_left = $urandom_range(1, 16);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Stop sending and wait for every expected result plus pipeline slack
    task automatic drain_results();
        i_s_axis_tvalid = 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        drain_results();
        i_cfg_index = idx;
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_HEATING_ENABLED) regulate_en = value[0];
        else if (idx == CFG_DEADBAND) band_deg = int'(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Receiver stall pattern
    always @(negedge i_clk) begin : drive_ready
        case (stall_mode)
            STALL_NONE: begin
                i_m_axis_tready = 1'b1;
            end
            STALL_RANDOM: begin
                i_m_axis_tready = ($urandom_range(0, 99) >= 35);
            end
            STALL_BURSTY: begin
                if (ready_left == 0) begin
                    i_m_axis_tready = ~i_m_axis_tready;
                    ready_left = i_m_axis_tready ? $urandom_range(1, 10) : $urandom_range(1, 15);
                end else begin
                    ready_left--;
                end
            end
            default: i_m_axis_tready = 1'b1;
        endcase
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_thermo_result exp_r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result item, tdata %h", o_m_axis_tdata);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (o_m_axis_tdata[7:0] !== exp_r.mean_deg) begin
                    $error("mean_deg: expected %0d, got %0d", exp_r.mean_deg,
                           o_m_axis_tdata[7:0]);
                    errors++;
                end
                if (o_m_axis_tdata[8] !== exp_r.heat_cmd) begin
                    $error("heat_cmd: expected %0d, got %0d", exp_r.heat_cmd,
                           o_m_axis_tdata[8]);
                    errors++;
                end
                if (o_m_axis_tdata[9] !== exp_r.cool_cmd) begin
                    $error("cool_cmd: expected %0d, got %0d", exp_r.cool_cmd,
                           o_m_axis_tdata[9]);
                    errors++;
                end
                if (o_m_axis_tdata[10] !== exp_r.led_on) begin
                    $error("led_on: expected %0d, got %0d", exp_r.led_on,
                           o_m_axis_tdata[10]);
                    errors++;
                end
            end
        end
    end

    // Regulation is off after reset: outputs stay off and the average at zero
    task automatic test_disabled_after_reset();
        send_reading(10'd1023, 8'd0);
        send_reading(10'd0, 8'd255);
        send_reading(10'd524, 8'd128);
    endtask

    // Scaling extremes and saturation, driving the cooler on a hot ring
    task automatic test_scale_and_cooling();
        write_register(CFG_HEATING_ENABLED, 8'd1);
        write_register(CFG_DEADBAND, 8'd0);
        send_reading(10'd1023, 8'd0);
        send_reading(10'd524, 8'd0);
        send_reading(10'd523, 8'd0);
        repeat (7) send_reading(10'd1023, 8'd0);
        // average equals setpoint: drives hold
        send_reading(10'd1023, 8'd255);
    endtask

    // Cold samples against a high setpoint: heater on, LED toggles after the blink period
    task automatic test_heating_blink();
        send_reading(10'd2, 8'd255);
        send_reading(10'd3, 8'd255);
        repeat (9) send_reading(10'd0, 8'd255);
    endtask

    // Widest dead band: nothing switches
    task automatic test_deadband_extremes();
        write_register(CFG_DEADBAND, 8'd255);
        send_reading(10'd0, 8'd255);
        send_reading(10'd1023, 8'd0);
    endtask

    // Disabling forces drives off and freezes the average
    task automatic test_disable_hold();
        write_register(CFG_HEATING_ENABLED, 8'd0);
        send_reading(10'd1023, 8'd0);
        write_register(CFG_HEATING_ENABLED, 8'd1);
    endtask

    // Phases of temperature runs around a setpoint, with some raw noise
    task automatic test_random_regulation();
        int phase;
        int sent;
        int db;
        int temp;
        int sp;
        int span;
        int slope;
        int run_len;
        for (phase = 0; phase < 12; phase++) begin
            case (phase)
                0: db = 0;
                1: db = 255;
                2: db = 1;
                default: db = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 255))
                                                          : int'($urandom_range(0, 12));
            endcase
            write_register(CFG_DEADBAND, db[7:0]);
            write_register(CFG_HEATING_ENABLED, (phase % 5 == 3) ? 8'd0 : 8'd1);

            sender_gaps = (phase % 3 != 0);
            burst_left  = 0;
            case ((phase + phase / 3) % 3)
                0: stall_mode = STALL_NONE;
                1: stall_mode = STALL_RANDOM;
                default: stall_mode = STALL_BURSTY;
            endcase

            sent = 0;
            while (sent < 135) begin
                if ($urandom_range(0, 9) < 2) begin
                    send_reading(10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
                    sent++;
                end else begin
                    temp    = int'($urandom_range(0, 255));
                    span    = (db > 40 ? 40 : db) + 12;
                    sp      = clamp_deg(temp + int'($urandom_range(0, 2 * span)) - span);
                    slope   = int'($urandom_range(0, 4)) - 2;
                    run_len = $urandom_range(5, 40);
                    if (run_len > 135 - sent) run_len = 135 - sent;
                    repeat (run_len) begin
                        temp = clamp_deg(temp + slope + int'($urandom_range(0, 2)) - 1);
                        send_reading(adc_for_degrees(temp), sp[7:0]);
                        sent++;
                    end
                end
            end
        end
        stall_mode  = STALL_NONE;
        sender_gaps = 1'b0;
    endtask

    initial begin : run_tests
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_disabled_after_reset();
        test_scale_and_cooling();
        test_heating_blink();
        test_deadband_extremes();
        test_disable_hold();
        test_random_regulation();

        drain_results();
        if (errors == 0) begin
            $display("averaged_deadband_thermostat verification clean");
        end else begin
            $display("averaged_deadband_thermostat verification failed");
        end
        $finish;
    end

    // Run limit, far above the slowest correct run
    initial begin : watchdog
        #2000000;
        $display("averaged_deadband_thermostat verification failed");
        $finish;
    end

endmodule
